[src/bptc_pkg.sv]
`default_nettype none

package bptc_pkg;

   // Field widths
   localparam int RAW_W     = 24;
   localparam int COEFF_W   = 16;
   localparam int RES_W     = 32;
   localparam int CSR_IDX_W = 3;

   // Calibration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SENS        = 3'd0,
      CSR_OFFSET      = 3'd1,
      CSR_SENS_TC     = 3'd2,
      CSR_OFFSET_TC   = 3'd3,
      CSR_REF_TEMP    = 3'd4,
      CSR_TEMP_SLOPE  = 3'd5
   } csr_index_type;

   localparam logic [COEFF_W-1:0] COEFF_ALL_ONES = 16'hFFFF;

   // 20.00 C reference point, and the offsets used for the low-temperature term
   localparam logic signed [19:0] TEMP_REF_CENTI = 20'sd2000;
   localparam logic signed [19:0] TD2_OFFSET     = 20'sd3500;
   localparam logic signed [18:0] LOW_TD_LIMIT   = -19'sd3500;

   typedef struct packed {
      logic [COEFF_W-1:0] sens;
      logic [COEFF_W-1:0] offset;
      logic [COEFF_W-1:0] sens_temp;
      logic [COEFF_W-1:0] offset_temp;
      logic [COEFF_W-1:0] ref_temp;
      logic [COEFF_W-1:0] temp_slope;
   } cfg_type;

   // First-order results handed to the second-order stages
   typedef struct packed {
      logic signed [19:0] temp;
      logic signed [36:0] off;
      logic signed [36:0] sens;
      logic [17:0]        t2;
      logic signed [18:0] td;
      logic signed [19:0] td2;
      logic               below_ref;
      logic               below_low;
      logic [RAW_W-1:0]   d1;
   } fo_type;

   // Corrected terms handed to the pressure stages
   typedef struct packed {
      logic signed [RES_W-1:0] temp_out;
      logic signed [42:0]      off_adj;
      logic signed [42:0]      sens_adj;
      logic [RAW_W-1:0]        d1;
   } so_type;

endpackage

`default_nettype wire

[src/bptc_ifs.sv]
`default_nettype none

interface bptc_req_if import bptc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] raw_pressure;
   logic [RAW_W-1:0] raw_temperature;

   modport source (output valid, raw_pressure, raw_temperature, input ready);
   modport sink   (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface bptc_rsp_if import bptc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [RES_W-1:0] pressure_out;
   logic signed [RES_W-1:0] temperature_centi;
   logic                    calib_bad;

   modport source (output valid, pressure_out, temperature_centi, calib_bad, input ready);
   modport sink   (input valid, pressure_out, temperature_centi, calib_bad, output ready);
endinterface

`default_nettype wire

[src/bptc_csr.sv]
`default_nettype none

module bptc_csr import bptc_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COEFF_W-1:0]   csr_wdata,
   output cfg_type                   cfg,
   output logic                      calib_bad
);

   cfg_type cfg_ff, cfg_in;

   // Register write decode; indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SENS:       cfg_in.sens        = csr_wdata;
            CSR_OFFSET:     cfg_in.offset      = csr_wdata;
            CSR_SENS_TC:    cfg_in.sens_temp   = csr_wdata;
            CSR_OFFSET_TC:  cfg_in.offset_temp = csr_wdata;
            CSR_REF_TEMP:   cfg_in.ref_temp    = csr_wdata;
            CSR_TEMP_SLOPE: cfg_in.temp_slope  = csr_wdata;
            default:        cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   // Flag a word stuck at all zeros or all ones
   always_comb begin
      calib_bad = 1'b0;
      if (cfg_ff.sens == '0 || cfg_ff.sens == COEFF_ALL_ONES) calib_bad = 1'b1;
      if (cfg_ff.offset == '0 || cfg_ff.offset == COEFF_ALL_ONES) calib_bad = 1'b1;
      if (cfg_ff.sens_temp == '0 || cfg_ff.sens_temp == COEFF_ALL_ONES) calib_bad = 1'b1;
      if (cfg_ff.offset_temp == '0 || cfg_ff.offset_temp == COEFF_ALL_ONES) calib_bad = 1'b1;
      if (cfg_ff.ref_temp == '0 || cfg_ff.ref_temp == COEFF_ALL_ONES) calib_bad = 1'b1;
      if (cfg_ff.temp_slope == '0 || cfg_ff.temp_slope == COEFF_ALL_ONES) calib_bad = 1'b1;
   end

endmodule

`default_nettype wire

[src/bptc_first_order.sv]
`default_nettype none

module bptc_first_order import bptc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire logic [RAW_W-1:0] raw_pressure,
   input  wire logic [RAW_W-1:0] raw_temperature,
   input  wire cfg_type          cfg,
   output logic                  out_valid,
   output fo_type                out_data
);

   logic v0_ff, v1_ff, v2_ff;

   logic signed [24:0] dt_ff, dt_in;
   logic [RAW_W-1:0]   d1_s0_ff, d1_s1_ff;
   logic signed [41:0] p6_ff, p6_in, p4_ff, p4_in, p3_ff, p3_in;
   logic signed [49:0] dtsq_ff, dtsq_in;
   fo_type             s2_ff, s2_in;

   logic               q_adj, off_adj, sens_adj;
   logic signed [18:0] q;
   logic signed [34:0] off_div;
   logic signed [33:0] sens_div;

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   // Stage 0: temperature difference from reference
   assign dt_in = $signed({1'b0, raw_temperature} - {1'b0, cfg.ref_temp, 8'h00});

   // Stage 1: the four products on dT
   assign p6_in   = dt_ff * $signed({1'b0, cfg.temp_slope});
   assign p4_in   = dt_ff * $signed({1'b0, cfg.offset_temp});
   assign p3_in   = dt_ff * $signed({1'b0, cfg.sens_temp});
   assign dtsq_in = dt_ff * dt_ff;

   // Stage 2: scale toward zero and form TEMP, OFF, SENS
   always_comb begin
      q_adj    = p6_ff[41] && (p6_ff[22:0] != '0);
      off_adj  = p4_ff[41] && (p4_ff[6:0] != '0);
      sens_adj = p3_ff[41] && (p3_ff[7:0] != '0);
      q        = p6_ff[41:23] + {18'd0, q_adj};
      off_div  = p4_ff[41:7] + {34'd0, off_adj};
      sens_div = p3_ff[41:8] + {33'd0, sens_adj};

      s2_in.temp      = TEMP_REF_CENTI + 20'(q);
      s2_in.off       = $signed({5'd0, cfg.offset, 16'd0}) + 37'(off_div);
      s2_in.sens      = $signed({6'd0, cfg.sens, 15'd0}) + 37'(sens_div);
      s2_in.below_ref = q[18];
      s2_in.below_low = q < LOW_TD_LIMIT;
      s2_in.t2        = q[18] ? dtsq_ff[48:31] : '0;
      s2_in.td        = q;
      s2_in.td2       = 20'(q) + TD2_OFFSET;
      s2_in.d1        = d1_s1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dt_ff    <= dt_in;
         d1_s0_ff <= raw_pressure;
         p6_ff    <= p6_in;
         p4_ff    <= p4_in;
         p3_ff    <= p3_in;
         dtsq_ff  <= dtsq_in;
         d1_s1_ff <= d1_s0_ff;
         s2_ff    <= s2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = s2_ff;

endmodule

`default_nettype wire

[src/bptc_second_order.sv]
`default_nettype none

module bptc_second_order import bptc_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   en,
   input  wire logic   in_valid,
   input  wire fo_type in_data,
   output logic        out_valid,
   output so_type      out_data
);

   logic v3_ff, v4_ff;

   logic signed [37:0] qq_full;
   logic signed [39:0] sq_full;
   logic [35:0]        qq_ff;
   logic [37:0]        sq_ff;
   fo_type             s3_ff;
   so_type             s4_ff, s4_in;

   logic [41:0] five_qq, seven_sq, eleven_sq, off2, sens2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= in_valid;
         v4_ff <= v3_ff;
      end
   end

   // Stage 3: squares of the distances below 20 C and below -15 C
   assign qq_full = in_data.td * in_data.td;
   assign sq_full = in_data.td2 * in_data.td2;

   // Stage 4: second-order terms (all non-negative, so shifts truncate correctly)
   always_comb begin
      five_qq   = (42'(qq_ff) << 2) + 42'(qq_ff);
      seven_sq  = (42'(sq_ff) << 3) - 42'(sq_ff);
      eleven_sq = (42'(sq_ff) << 3) + (42'(sq_ff) << 1) + 42'(sq_ff);
      off2      = '0;
      sens2     = '0;
      if (s3_ff.below_ref) begin
         off2  = (five_qq >> 1) + (s3_ff.below_low ? seven_sq : 42'd0);
         sens2 = (five_qq >> 2) + (s3_ff.below_low ? (eleven_sq >> 1) : 42'd0);
      end
      s4_in.temp_out = 32'(s3_ff.temp) - 32'(s3_ff.t2);
      s4_in.off_adj  = 43'(s3_ff.off) - $signed({1'b0, off2});
      s4_in.sens_adj = 43'(s3_ff.sens) - $signed({1'b0, sens2});
      s4_in.d1       = s3_ff.d1;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qq_ff <= qq_full[35:0];
         sq_ff <= sq_full[37:0];
         s3_ff <= in_data;
         s4_ff <= s4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = s4_ff;

endmodule

`default_nettype wire

[src/bptc_pressure.sv]
`default_nettype none

module bptc_pressure import bptc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire so_type             in_data,
   input  wire logic               calib_bad,
   output logic                    out_valid,
   output logic signed [RES_W-1:0] pressure_out,
   output logic signed [RES_W-1:0] temperature_centi,
   output logic                    out_calib_bad
);

   logic v5_ff, v6_ff, v7_ff, out_valid_ff;

   logic [45:0]             plo_ff, plo_in;
   logic signed [45:0]      phi_ff, phi_in;
   logic signed [67:0]      prod_ff, prod_in;
   logic signed [47:0]      x_ff, x_in;
   logic signed [42:0]      off5_ff, off6_ff;
   logic signed [RES_W-1:0] temp5_ff, temp6_ff, temp7_ff;
   logic                    prod_adj, x_adj;
   logic signed [RES_W-1:0] press_ff, press_in;
   logic signed [RES_W-1:0] temp_out_ff;
   logic                    bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         v5_ff        <= in_valid;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         out_valid_ff <= v7_ff;
      end
   end

   // Stage 5: raw pressure times SENS, split into two partial products
   assign plo_in = in_data.d1 * in_data.sens_adj[21:0];
   assign phi_in = $signed({1'b0, in_data.d1}) * $signed(in_data.sens_adj[42:22]);

   // Stage 6: recombine
   assign prod_in = (68'(phi_ff) <<< 22) + 68'(plo_ff);

   // Stage 7: divide by 2^21 toward zero and take off OFF
   assign prod_adj = prod_ff[67] && (prod_ff[20:0] != '0);
   assign x_in     = 48'($signed(prod_ff[67:21])) + {47'd0, prod_adj} - 48'(off6_ff);

   // Stage 8: divide by 2^15 toward zero, keep the low 32 bits
   assign x_adj    = x_ff[47] && (x_ff[14:0] != '0);
   assign press_in = x_ff[46:15] + {31'd0, x_adj};

   always_ff @(posedge clock) begin
      if (en) begin
         plo_ff      <= plo_in;
         phi_ff      <= phi_in;
         off5_ff     <= in_data.off_adj;
         temp5_ff    <= in_data.temp_out;
         prod_ff     <= prod_in;
         off6_ff     <= off5_ff;
         temp6_ff    <= temp5_ff;
         x_ff        <= x_in;
         temp7_ff    <= temp6_ff;
         press_ff    <= press_in;
         temp_out_ff <= temp7_ff;
         bad_ff      <= calib_bad;
      end
   end

   assign out_valid         = out_valid_ff;
   assign pressure_out      = press_ff;
   assign temperature_centi = temp_out_ff;
   assign out_calib_bad     = bad_ff;

endmodule

`default_nettype wire

[src/baro_pressure_temp_compensation.sv]
`default_nettype none
// Barometer second-order temperature compensation.
// req_ch carries one raw pressure / raw temperature conversion pair per item;
// rsp_ch returns pressure in pascals, temperature in hundredths of a degree
// and a flag for calibration words stuck at 0 or 0xFFFF. Both channels use a
// valid/ready handshake. The six calibration words are written through the
// csr_ port (write enable, index, data); the user must write them only while
// no item is in flight; the block itself does not enforce it. Pipeline:
// nine register stages. Throughput: one item per cycle unless rsp_ch
// stalls, set by the fully pipelined datapath (one multiplier level per
// stage, the 24 x 43 bit pressure product split into two partial products
// over two stages). Reset clears the calibration words and all valid bits;
// the pipeline is empty and ready at once afterwards.
// When rsp_ch stalls with a result waiting, the whole pipeline holds and
// req_ch.ready drops; req_ch.ready stays high as long as the output register
// is empty or being taken, so nothing is lost or repeated.

module baro_pressure_temp_compensation import bptc_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   bptc_req_if.sink                  req_ch,
   bptc_rsp_if.source                rsp_ch,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COEFF_W-1:0]   csr_wdata
);

   cfg_type cfg;
   logic    calib_bad;
   logic    en;
   logic    fo_valid, so_valid, out_valid;
   fo_type  fo_data;
   so_type  so_data;

   // Pipeline advances unless a finished item is stuck at the output
   assign en           = !out_valid || rsp_ch.ready;
   assign req_ch.ready = en;

   bptc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .calib_bad (calib_bad)
   );

   bptc_first_order u_first (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .in_valid        (req_ch.valid),
      .raw_pressure    (req_ch.raw_pressure),
      .raw_temperature (req_ch.raw_temperature),
      .cfg             (cfg),
      .out_valid       (fo_valid),
      .out_data        (fo_data)
   );

   bptc_second_order u_second (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fo_valid),
      .in_data   (fo_data),
      .out_valid (so_valid),
      .out_data  (so_data)
   );

   bptc_pressure u_press (
      .clock             (clock),
      .reset             (reset),
      .en                (en),
      .in_valid          (so_valid),
      .in_data           (so_data),
      .calib_bad         (calib_bad),
      .out_valid         (out_valid),
      .pressure_out      (rsp_ch.pressure_out),
      .temperature_centi (rsp_ch.temperature_centi),
      .out_calib_bad     (rsp_ch.calib_bad)
   );

   assign rsp_ch.valid = out_valid;

endmodule

`default_nettype wire

[test/testbench.sv]
`default_nettype none

module testbench import bptc_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [RAW_W-1:0]     RAW_MAX               = '1;
   localparam int                   MISMATCH_REPORT_LIMIT = 10;
   localparam int                   SEGMENT_COUNT         = 9;
   localparam int                   SEGMENT_ITEMS         = 180;
   // indexes past the calibration list; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SPARE_LO      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SPARE_HI      = 3'd7;
   // compensation thresholds in hundredths of a degree
   localparam longint               ROOM_CENTI            = 2000;
   localparam longint               COLD_CENTI            = -1500;
   localparam longint               DT_SQ_DIV             = 64'sd2147483648;

   typedef logic [COEFF_W-1:0] coeff_set_type [6];

   typedef struct packed {
      logic signed [RES_W-1:0] pressure_out;
      logic signed [RES_W-1:0] temperature_centi;
      logic                    calib_bad;
   } reading_type;

   localparam coeff_set_type TYPICAL_COEFFS  = '{16'd40127, 16'd36924, 16'd23317,
                                                 16'd23282, 16'd33464, 16'd28312};
   localparam coeff_set_type ALL_ONES_COEFFS = '{16'hFFFF, 16'hFFFF, 16'hFFFF,
                                                 16'hFFFF, 16'hFFFF, 16'hFFFF};
   localparam coeff_set_type MIN_COEFFS      = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1};
   localparam coeff_set_type BAD_MIX_COEFFS  = '{16'd0, 16'hFFFF, 16'd23317,
                                                 16'd0, 16'd33464, 16'hFFFF};
   // high reference temperature: most conversions land in the cold branches
   localparam coeff_set_type HOT_REF_COEFFS  = '{16'd20000, 16'd40000, 16'd60000,
                                                 16'd1000, 16'd65534, 16'd65534};
   localparam logic [RAW_W-1:0] TYPICAL_REF_RAW = 24'd33464 * 24'd256;

   // Expected compensated readings, predicted from the calibration copy
   class compensation_scoreboard;
      logic [COEFF_W-1:0] coeff [6];
      reading_type        expected_readings [$];
      int                 mismatches;

      function new();
         foreach (coeff[i]) coeff[i] = '0;
         mismatches = 0;
      endfunction

      function void set_coeff(csr_index_type idx, logic [COEFF_W-1:0] value);
         coeff[idx] = value;
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction

      function reading_type compensate(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t);
         longint      d1, d2, c1, c2, c3, c4, c5, c6;
         longint      dt, temp, off, sens, t2, off2, sens2, td, td2, p;
         reading_type r;
         d1 = raw_p;
         d2 = raw_t;
         c1 = coeff[CSR_SENS];
         c2 = coeff[CSR_OFFSET];
         c3 = coeff[CSR_SENS_TC];
         c4 = coeff[CSR_OFFSET_TC];
         c5 = coeff[CSR_REF_TEMP];
         c6 = coeff[CSR_TEMP_SLOPE];
         t2 = 0;
         off2 = 0;
         sens2 = 0;

         // first order; longint division truncates toward zero
         dt   = d2 - c5 * 256;
         temp = ROOM_CENTI + (dt * c6) / 8388608;
         off  = c2 * 65536 + (c4 * dt) / 128;
         sens = c1 * 32768 + (c3 * dt) / 256;

         // second order below room temperature, extra term when very cold
         if (temp < ROOM_CENTI) begin
            td    = temp - ROOM_CENTI;
            t2    = (dt * dt) / DT_SQ_DIV;
            off2  = 5 * td * td / 2;
            sens2 = 5 * td * td / 4;
            if (temp < COLD_CENTI) begin
               td2   = temp - COLD_CENTI;
               off2  += 7 * td2 * td2;
               sens2 += 11 * td2 * td2 / 2;
            end
         end
         temp -= t2;
         off  -= off2;
         sens -= sens2;
         p = ((d1 * sens) / 2097152 - off) / 32768;

         r.pressure_out      = p[RES_W-1:0];
         r.temperature_centi = temp[RES_W-1:0];
         r.calib_bad         = 1'b0;
         foreach (coeff[i]) begin
            if (coeff[i] == '0 || coeff[i] == COEFF_ALL_ONES) r.calib_bad = 1'b1;
         end
         return r;
      endfunction

      function void note_reading(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t);
         expected_readings.push_back(compensate(raw_p, raw_t));
      endfunction

      function void check_reading(reading_type got);
         reading_type want;
         if (expected_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= MISMATCH_REPORT_LIMIT)
               $display("%0t: unexpected result p=%0d t=%0d bad=%0b", $realtime,
                        got.pressure_out, got.temperature_centi, got.calib_bad);
            return;
         end
         want = expected_readings.pop_front();
         if (got.pressure_out !== want.pressure_out ||
             got.temperature_centi !== want.temperature_centi ||
             got.calib_bad !== want.calib_bad) begin
            mismatches++;
            if (mismatches <= MISMATCH_REPORT_LIMIT)
               $display("%0t: mismatch p=%0d/%0d t=%0d/%0d bad=%0b/%0b (exp/got)",
                        $realtime, want.pressure_out, got.pressure_out,
                        want.temperature_centi, got.temperature_centi,
                        want.calib_bad, got.calib_bad);
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [COEFF_W-1:0]     csr_wdata;
   int unsigned            sender_idle_pct   = 20;
   int unsigned            receiver_idle_pct = 69;
   compensation_scoreboard sb = new();

   bptc_req_if req_ch ();
   bptc_rsp_if rsp_ch ();

   baro_pressure_temp_compensation u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1;
      clock = 1'b1;
      #1;
      clock = 1'b0;
   end

   // Result side: random back-pressure, check every accepted item
   always begin
      rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      @(posedge clock);
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready)
         sb.check_reading('{rsp_ch.pressure_out, rsp_ch.temperature_centi,
                            rsp_ch.calib_bad});
   end

   // Offer one conversion pair; valid stays up for a following item
   task automatic send_reading(input logic [RAW_W-1:0] raw_p,
                               input logic [RAW_W-1:0] raw_t);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.raw_pressure    <= raw_p;
      req_ch.raw_temperature <= raw_t;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_reading(raw_p, raw_t);
   endtask

   // Stop sending and let every outstanding result come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Write all six words, then the two unused indexes with junk
   task automatic load_coeffs(input coeff_set_type words);
      csr_index_type idx;
      idx = idx.first();
      repeat (idx.num()) begin
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= words[idx];
         @(posedge clock);
         sb.set_coeff(idx, words[idx]);
         idx = idx.next();
      end
      csr_index <= CSR_IDX_SPARE_LO;
      csr_wdata <= COEFF_W'($urandom);
      @(posedge clock);
      csr_index <= CSR_IDX_SPARE_HI;
      csr_wdata <= COEFF_W'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic coeff_set_type segment_coeffs(int seg);
      coeff_set_type words;
      case (seg)
         0, 8:    words = TYPICAL_COEFFS;
         1:       words = ALL_ONES_COEFFS;
         3:       words = BAD_MIX_COEFFS;
         5:       words = MIN_COEFFS;
         6:       words = HOT_REF_COEFFS;
         default: foreach (words[i]) words[i] = COEFF_W'($urandom);
      endcase
      return words;
   endfunction

   // Mix of full-range pairs, pairs near the room and cold thresholds, extremes
   task automatic send_random_reading();
      logic [RAW_W-1:0] raw_p;
      logic [RAW_W-1:0] raw_t;
      int               ref_raw;
      int               t;
      raw_p   = RAW_W'($urandom);
      raw_t   = RAW_W'($urandom);
      ref_raw = int'(sb.coeff[CSR_REF_TEMP]) * 256;
      t       = int'(raw_t);
      case ($urandom_range(9))
         4, 5:    t = ref_raw + int'($urandom_range(131072)) - 65536;
         6, 7:    t = ref_raw - int'($urandom_range(1 << 22));
         8, 9: begin
            case ($urandom_range(2))
               0:       raw_p = '0;
               1:       raw_p = RAW_MAX;
               default: ;
            endcase
            case ($urandom_range(2))
               0:       t = 0;
               1:       t = int'(RAW_MAX);
               default: ;
            endcase
         end
         default: ;
      endcase
      if (t < 0) t = 0;
      if (t > int'(RAW_MAX)) t = int'(RAW_MAX);
      raw_t = t[RAW_W-1:0];
      send_reading(raw_p, raw_t);
   endtask

   initial begin
      reset                  <= 1'b1;
      csr_we                 <= 1'b0;
      csr_index              <= CSR_SENS;
      csr_wdata              <= '0;
      req_ch.valid           <= 1'b0;
      req_ch.raw_pressure    <= '0;
      req_ch.raw_temperature <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // calibration still all zero after reset: flagged, still computed
      send_reading('0, '0);
      send_reading(RAW_MAX, RAW_MAX);
      wait_drained();

      // typical calibration: field extremes and both temperature thresholds
      load_coeffs(TYPICAL_COEFFS);
      send_reading('0, '0);
      send_reading(RAW_MAX, RAW_MAX);
      send_reading('0, RAW_MAX);
      send_reading(RAW_MAX, '0);
      send_reading(RAW_MAX, TYPICAL_REF_RAW);
      send_reading(24'd9000000, TYPICAL_REF_RAW - 24'd1);
      send_reading(24'd9000000, TYPICAL_REF_RAW - 24'd297);
      send_reading(24'd6000000, TYPICAL_REF_RAW - 24'd1030000);
      send_reading(24'd6000000, TYPICAL_REF_RAW - 24'd1040000);
      send_reading(24'd8000000, 24'd9000000);
      wait_drained();

      // calibration words stuck at zero and all ones
      load_coeffs(BAD_MIX_COEFFS);
      send_reading(RAW_MAX, '0);
      send_reading('0, RAW_MAX);
      send_reading(24'd8000000, 24'd8000000);

      // random segments; idle mix changes every third segment
      for (int seg = 0; seg < SEGMENT_COUNT; seg++) begin
         wait_drained();
         sender_idle_pct   = (seg < 3) ? 20 : ((seg < 6) ? 69 : 0);
         receiver_idle_pct = (seg < 3) ? 69 : ((seg < 6) ? 20 : 0);
         load_coeffs(segment_coeffs(seg));
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            if (n == SEGMENT_ITEMS / 2) wait_drained();
            send_random_reading();
         end
      end

      wait_drained();
      repeat (16) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
src/bptc_pkg.sv
src/bptc_ifs.sv
src/bptc_csr.sv
src/bptc_first_order.sv
src/bptc_second_order.sv
src/bptc_pressure.sv
src/baro_pressure_temp_compensation.sv
test/testbench.sv
